/* hw/rtl/dhc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared widths, constants and colour ramp for the distance heatmap colouriser.
// ----------------------------------------------------------------------------
package dhc_pkg;

  localparam int unsigned LevelW = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = 34;
  localparam int unsigned RemW   = 35;
  localparam int unsigned DivW   = 31;
  localparam int unsigned QuotW  = 20;
  localparam int unsigned IntBits = 4;
  localparam int unsigned BlendW = 18;
  localparam int unsigned RhsW   = 36;
  localparam int unsigned NumChan = 3;

  localparam logic [QuotW-1:0] PosMax = 20'(10 << 16);

  typedef enum logic [0:0] {
    REG_GOOD_LEVEL = 1'b0,
    REG_BAD_LEVEL  = 1'b1
  } cfg_reg_t;

  // Ramp entry in halves, packed {red, green, blue}
  function automatic logic [5:0] ramp_entry(input logic [3:0] ix);
    logic [5:0] e;
    unique case (ix)
      4'd0:    e = {2'd0, 2'd0, 2'd0};
      4'd1:    e = {2'd0, 2'd0, 2'd2};
      4'd2:    e = {2'd0, 2'd2, 2'd2};
      4'd3:    e = {2'd0, 2'd2, 2'd0};
      4'd4:    e = {2'd2, 2'd2, 2'd0};
      4'd5:    e = {2'd2, 2'd0, 2'd0};
      4'd6:    e = {2'd2, 2'd0, 2'd2};
      4'd7:    e = {2'd1, 2'd1, 2'd2};
      4'd8:    e = {2'd2, 2'd1, 2'd1};
      4'd9:    e = {2'd2, 2'd2, 2'd1};
      default: e = {2'd2, 2'd2, 2'd2};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/distance_heatmap_colorizer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// distance_heatmap_colorizer_unit
// Distance to heatmap colour: band position, pipelined divide, ramp blend and
// square-root gamma by binary search.
// Throughput: one request per cycle; a single stall enable freezes all stages
// while the output register holds an untaken result.
// Reset: synchronous active low; clears valid bits and loads the default levels.
// ----------------------------------------------------------------------------
module distance_heatmap_colorizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_distance,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);

  localparam int unsigned NDiv = dhc_pkg::QuotW;
  localparam int unsigned NGam = dhc_pkg::ChanW;

  logic [dhc_pkg::LevelW-1:0] good_level_r, bad_level_r;
  logic en;

  // stage A
  logic                     a_vld_r, a_sat_r;
  logic [dhc_pkg::NumW-1:0] a_m_r;
  logic [dhc_pkg::DivW-1:0] a_dv_r;
  logic                     a_sat_nxt;
  logic [dhc_pkg::NumW-1:0] a_m_nxt;
  logic [dhc_pkg::DivW-1:0] a_dv_nxt;
  logic [dhc_pkg::LevelW-1:0] span;

  // divider stages
  logic                      d_vld_r [0:NDiv];
  logic                      d_sat_r [0:NDiv];
  logic [dhc_pkg::RemW-1:0]  d_rem_r [0:NDiv];
  logic [dhc_pkg::DivW-1:0]  d_dv_r  [0:NDiv];
  logic [dhc_pkg::QuotW-1:0] d_q_r   [0:NDiv];

  // blend and gamma stages
  logic                       p_vld_r, r_vld_r;
  logic [dhc_pkg::BlendW-1:0] p_v_r [0:dhc_pkg::NumChan-1];
  logic [dhc_pkg::BlendW-1:0] p_v_nxt [0:dhc_pkg::NumChan-1];
  logic [dhc_pkg::RhsW-1:0]   r_rhs_r [0:dhc_pkg::NumChan-1];
  logic                       g_vld_r [0:NGam];
  logic [dhc_pkg::RhsW-1:0]   g_rhs_r [0:NGam-1][0:dhc_pkg::NumChan-1];
  logic [dhc_pkg::ChanW-1:0]  g_n_r   [0:NGam][0:dhc_pkg::NumChan-1];

  logic [dhc_pkg::QuotW-1:0] pos;
  logic [3:0]                ix;
  logic [15:0]               w;
  logic [5:0]                e_lo, e_hi;

  assign en        = !g_vld_r[NGam] || out_ready;
  assign in_ready  = en;
  assign out_valid = g_vld_r[NGam];
  assign out_red   = g_n_r[NGam][0];
  assign out_green = g_n_r[NGam][1];
  assign out_blue  = g_n_r[NGam][2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_level_r <= 24'd65536;
      bad_level_r  <= 24'd98304;
    end else if (cfg_we) begin
      unique case (dhc_pkg::cfg_reg_t'(cfg_index))
        dhc_pkg::REG_GOOD_LEVEL: good_level_r <= cfg_data;
        dhc_pkg::REG_BAD_LEVEL:  bad_level_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // band select and rational operands
  always_comb begin
    span      = bad_level_r - good_level_r;
    a_sat_nxt = 1'b0;
    if (in_distance < good_level_r) begin
      a_m_nxt  = 34'(in_distance) * 34'd33;
      a_dv_nxt = 31'(good_level_r) * 31'd10;
    end else if (in_distance < bad_level_r) begin
      a_m_nxt  = (34'({span, 1'b0}) + 34'(in_distance - good_level_r)) * 34'd33;
      a_dv_nxt = 31'(span) * 31'd20;
    end else if (bad_level_r == '0) begin
      a_sat_nxt = 1'b1;
      a_m_nxt   = '0;
      a_dv_nxt  = 31'd1;
    end else begin
      a_m_nxt  = 34'(bad_level_r) * 34'd539 + 34'(in_distance) * 34'd55;
      a_dv_nxt = 31'(bad_level_r) * 31'd120;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      a_sat_r <= a_sat_nxt;
      a_m_r   <= a_m_nxt;
      a_dv_r  <= a_dv_nxt;
    end
  end

  // overflow check, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NDiv; j++) d_vld_r[j] <= 1'b0;
    end else if (en) begin
      d_vld_r[0] <= a_vld_r;
      d_sat_r[0] <= a_sat_r ||
                    (35'(a_m_r) >= {a_dv_r, {dhc_pkg::IntBits{1'b0}}});
      d_rem_r[0] <= 35'(a_m_r);
      d_dv_r[0]  <= a_dv_r;
      d_q_r[0]   <= '0;
      for (int j = 0; j < NDiv; j++) begin
        d_vld_r[j+1] <= d_vld_r[j];
        d_sat_r[j+1] <= d_sat_r[j];
        d_dv_r[j+1]  <= d_dv_r[j];
      end
    end
  end

  for (genvar j = 0; j < NDiv; j++) begin : g_div
    logic [dhc_pkg::RemW-1:0] trial, cmp;
    always_comb begin
      if (j < dhc_pkg::IntBits) begin
        trial = d_rem_r[j];
        cmp   = 35'(d_dv_r[j]) << (dhc_pkg::IntBits - 1 - j);
      end else begin
        trial = d_rem_r[j] << 1;
        cmp   = 35'(d_dv_r[j]);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= cmp) begin
          d_rem_r[j+1] <= trial - cmp;
          d_q_r[j+1]   <= {d_q_r[j][NDiv-2:0], 1'b1};
        end else begin
          d_rem_r[j+1] <= trial;
          d_q_r[j+1]   <= {d_q_r[j][NDiv-2:0], 1'b0};
        end
      end
    end
  end

  // clamp and blend
  always_comb begin
    if (d_sat_r[NDiv] || d_q_r[NDiv] > dhc_pkg::PosMax) pos = dhc_pkg::PosMax;
    else pos = d_q_r[NDiv];
    ix   = pos[19:16];
    w    = pos[15:0];
    e_lo = dhc_pkg::ramp_entry(ix);
    e_hi = dhc_pkg::ramp_entry(ix + 4'd1);
    for (int c = 0; c < dhc_pkg::NumChan; c++) begin
      p_v_nxt[c] = 18'(w) * 18'(e_hi[4-2*c +: 2]) +
                   (18'd65536 - 18'(w)) * 18'(e_lo[4-2*c +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= d_vld_r[NDiv];
      r_vld_r <= p_vld_r;
      for (int c = 0; c < dhc_pkg::NumChan; c++) begin
        p_v_r[c]   <= p_v_nxt[c];
        r_rhs_r[c] <= 36'(p_v_r[c]) * 36'd260100;
      end
    end
  end

  // gamma: binary search for round(255*sqrt(v / 2^17)), with v the blend value, one bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NGam; k++) g_vld_r[k] <= 1'b0;
    end else if (en) begin
      g_vld_r[0] <= r_vld_r;
      for (int k = 0; k < NGam; k++) g_vld_r[k+1] <= g_vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < dhc_pkg::NumChan; c++) begin
        g_rhs_r[0][c] <= r_rhs_r[c];
        g_n_r[0][c]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < NGam; k++) begin : g_gam
    for (genvar c = 0; c < dhc_pkg::NumChan; c++) begin : g_ch
      logic [dhc_pkg::ChanW-1:0] cand;
      logic [dhc_pkg::ChanW:0]   odd;
      logic [dhc_pkg::RhsW-1:0]  lhs;
      always_comb begin
        cand = g_n_r[k][c] | 8'(1 << (NGam - 1 - k));
        odd  = {cand, 1'b0} - 9'd1;
        lhs  = (36'(odd) * 36'(odd)) << 17;
      end
      if (k + 1 < NGam) begin : g_fwd
        always_ff @(posedge clk) begin
          if (en) g_rhs_r[k+1][c] <= g_rhs_r[k][c];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          g_n_r[k+1][c] <= (lhs <= g_rhs_r[k][c]) ? cand : g_n_r[k][c];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r[NDiv] && !d_sat_r[NDiv] |-> d_rem_r[NDiv] < 35'(d_dv_r[NDiv]))
    else $error("divider remainder not below divisor");
  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> p_v_r[0] <= 18'd131072 && p_v_r[1] <= 18'd131072 &&
                p_v_r[2] <= 18'd131072)
    else $error("blend value out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !en |=> a_vld_r && $stable(a_m_r))
    else $error("request dropped during stall");
`endif

endmodule
`default_nettype wire

/* verif/tb_distance_heatmap_colorizer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_distance_heatmap_colorizer_unit
// Runs distances through the heatmap colouriser under several level settings,
// with random gaps on the request side and random stalls on the result side.
// Every accepted distance is turned into an expected colour by an independent
// band/ramp/gamma calculation, and each result is checked against the oldest.
// ----------------------------------------------------------------------------
module tb_distance_heatmap_colorizer_unit;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  class colour_scoreboard;
    logic [23:0] good_lvl;
    logic [23:0] bad_lvl;
    colour_t     pending_colours[$];
    int          errors;
    int          checked;

    function void set_levels(logic [23:0] g, logic [23:0] b);
      good_lvl = g;
      bad_lvl  = b;
    endfunction

    function logic [1:0] ramp_half(int ix, int ch);
      logic [5:0] e;
      case (ix)
        0:       e = 6'b00_00_00;
        1:       e = 6'b00_00_10;
        2:       e = 6'b00_10_10;
        3:       e = 6'b00_10_00;
        4:       e = 6'b10_10_00;
        5:       e = 6'b10_00_00;
        6:       e = 6'b10_00_10;
        7:       e = 6'b01_01_10;
        8:       e = 6'b10_01_01;
        9:       e = 6'b10_10_01;
        default: e = 6'b10_10_10;
      endcase
      return e[5 - 2*ch -: 2];
    endfunction

    function longint unsigned ramp_position(longint unsigned d);
      longint unsigned g, b, span, pos;
      g = good_lvl;
      b = bad_lvl;
      if (d < g) begin
        pos = (d * 33 * 65536) / (10 * g);
      end else if (d < b) begin
        span = b - g;
        pos  = (65536 * 33 * (2 * span + (d - g))) / (20 * span);
      end else if (b == 0) begin
        pos = 64'd10 << 16;
      end else begin
        pos = (65536 * 11 * (49 * b + 5 * d)) / (120 * b);
      end
      if (pos > (64'd10 << 16)) pos = 64'd10 << 16;
      return pos;
    endfunction

    function logic [7:0] sqrt_gamma(longint unsigned v);
      longint unsigned odd, rhs;
      int n;
      logic [7:0] best;
      best = 0;
      rhs  = 260100 * v;
      for (n = 1; n <= 255; n++) begin
        odd = 2 * n - 1;
        if (((odd * odd) << 17) <= rhs) best = n[7:0];
        else break;
      end
      return best;
    endfunction

    function void note_distance(logic [23:0] d);
      longint unsigned pos, w, v;
      int ix, ch;
      logic [7:0] chan[3];
      colour_t c;
      pos = ramp_position(d);
      ix  = int'(pos >> 16);
      w   = pos & 64'hFFFF;
      if (ix > 10) ix = 10;
      for (ch = 0; ch < 3; ch++) begin
        v = w * ramp_half(ix + 1, ch) + (65536 - w) * ramp_half(ix, ch);
        chan[ch] = sqrt_gamma(v);
      end
      c.red   = chan[0];
      c.green = chan[1];
      c.blue  = chan[2];
      pending_colours = {pending_colours, c};
    endfunction

    function void check_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      colour_t e;
      checked++;
      if (pending_colours.size() == 0) begin
        $error("result with no request outstanding: red %0d green %0d blue %0d", r, g, b);
        errors++;
        return;
      end
      e = pending_colours.pop_front();
      if (r !== e.red) begin
        $error("red: expected %0d, actual %0d", e.red, r);
        errors++;
      end
      if (g !== e.green) begin
        $error("green: expected %0d, actual %0d", e.green, g);
        errors++;
      end
      if (b !== e.blue) begin
        $error("blue: expected %0d, actual %0d", e.blue, b);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned Latency    = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] in_distance;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  colour_scoreboard colours;
  bit          gaps_on;
  int unsigned quiet_cycles;
  int unsigned sent;

  distance_heatmap_colorizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_distance(in_distance),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= gaps_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) colours.check_colour(out_red, out_green, out_blue);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_distance(input logic [23:0] d);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_distance <= d;
    do @(posedge clk); while (!in_ready);
    colours.note_distance(d);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (colours.pending_colours.size() != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
  endtask

  task automatic write_level(input dhc_pkg::cfg_reg_t idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dhc_pkg::REG_GOOD_LEVEL) colours.good_lvl = val;
    else colours.bad_lvl = val;
    @(negedge clk);
  endtask

  function automatic logic [23:0] clip24(longint v);
    if (v < 0) return 24'd0;
    if (v > 64'hFFFFFF) return 24'hFFFFFF;
    return v[23:0];
  endfunction

  function automatic logic [23:0] pick_distance();
    longint g, b;
    g = colours.good_lvl;
    b = colours.bad_lvl;
    case ($urandom_range(0, 7))
      0:       return 24'($urandom);
      1:       return clip24(g + $signed($urandom_range(0, 64)) - 32);
      2:       return clip24(b + $signed($urandom_range(0, 64)) - 32);
      3:       return 24'($urandom_range(0, 131071));
      4:       return clip24(b + longint'($urandom_range(0, 1000)) * (b / 40 + 1));
      5:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
      default: return clip24(longint'($urandom_range(0, 1023)) * (b + g + 1) / 700);
    endcase
  endfunction

  logic [23:0] good_set[10] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'd0,
                                24'd40000, 24'hFFFFFF, 24'd1, 24'd300, 24'd65536};
  logic [23:0] bad_set[10]  = '{24'd98304, 24'hFFFFFF, 24'd1, 24'd0, 24'd98304,
                                24'd40000, 24'hFFFFFF, 24'd1, 24'd0, 24'd98304};
  logic [23:0] edge_set[12] = '{24'd0, 24'd1, 24'd65535, 24'd65536, 24'd65537, 24'd98303,
                                24'd98304, 24'd98305, 24'd1245184, 24'd1277952,
                                24'hFFFFFF, 24'h800000};

  initial begin
    int p, i;
    colours = new();
    colours.set_levels(24'd65536, 24'd98304);
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_distance = '0;
    cfg_we      = 1'b0;
    cfg_index   = dhc_pkg::REG_GOOD_LEVEL;
    cfg_data    = '0;
    out_ready   = 1'b0;
    gaps_on     = 1'b1;
    sent        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (edge_set[k]) send_distance(edge_set[k]);

    for (p = 0; p < 10; p++) begin
      if (p == 8) begin
        good_set[p] = 24'($urandom_range(1, 200000));
        bad_set[p]  = 24'(good_set[p] + $urandom_range(1, 300000));
      end
      drain();
      write_level(dhc_pkg::REG_GOOD_LEVEL, good_set[p]);
      write_level(dhc_pkg::REG_BAD_LEVEL, bad_set[p]);
      gaps_on = (p != 2);
      for (i = 0; i < 190; i++) begin
        if (p == 4 && i == 95) drain();
        send_distance(pick_distance());
      end
    end

    drain();
    $display("Sent %0d distances across 10 level settings, checked %0d colours.",
             sent, colours.checked);
    $display("Settings covered zero, equal, inverted and full-scale levels.");
    if (colours.errors == 0 && colours.pending_colours.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
